// File: hdl/ddo_pkg.sv
package ddo_pkg;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned CORDIC_STEPS_MAX = 30;
    localparam int unsigned CNT_W            = 5;
    localparam int unsigned CFG_W            = 24;
    localparam int unsigned CNT_IDX_W        = 1;

    // Register indexes on the configuration port
    localparam logic [CNT_IDX_W-1:0] REG_LENGTH_PER_TICK = 1'b0;
    localparam logic [CNT_IDX_W-1:0] REG_ANGLE_PER_TICK  = 1'b1;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_YAW,
        MUL_LEN,
        MUL_XLO,
        MUL_XHI,
        MUL_YLO,
        MUL_YHI
    } t_mul_sel;

    typedef struct packed {
        logic             ld_in;
        t_mul_sel         mul_sel;
        logic             ld_yaw;
        logic             cinit;
        logic             citer;
        logic             cfin;
        logic             ld_lo;
        logic             term_x;
        logic             term_y;
        logic             add_x;
        logic             add_y;
        logic             ld_out;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [CNT_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/ddo_if.sv
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic               read_ok;

    modport source (output valid, output left_count, output right_count, output read_ok,
                    input ready);
    modport sink   (input valid, input left_count, input right_count, input read_ok,
                    output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] pose_x;
    logic signed [63:0] pose_y;
    logic        [31:0] heading;
    logic               success;

    modport source (output valid, output pose_x, output pose_y, output heading,
                    output success, input ready);
    modport sink   (input valid, input pose_x, input pose_y, input heading,
                    input success, output ready);
endinterface

// File: hdl/ddo_ctrl.sv
module ddo_ctrl #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_read_ok,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output ddo_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MYAW, S_MLEN, S_CINIT, S_CITER, S_CFIN,
        S_MXL, S_MXH, S_MYL, S_MYH, S_TY, S_AY, S_OUT
    } t_state;

    localparam logic [ddo_pkg::CNT_W-1:0] LAST = ddo_pkg::CNT_W'(CORDIC_STEPS - 1);

    t_state                    r_state, n_state;
    logic [ddo_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic                      accept, slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = ddo_pkg::MUL_NONE;
        o_cmd.cnt     = r_cnt;
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_cmd.ld_in = accept;
                if (accept) begin
                    n_state = i_read_ok ? S_MYAW : S_OUT;
                end
            end
            S_MYAW: begin
                o_cmd.mul_sel = ddo_pkg::MUL_YAW;
                n_state = S_MLEN;
            end
            S_MLEN: begin
                o_cmd.mul_sel = ddo_pkg::MUL_LEN;
                o_cmd.ld_yaw  = 1'b1;
                n_state = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.cinit = 1'b1;
                n_cnt   = '0;
                n_state = S_CITER;
            end
            S_CITER: begin
                o_cmd.citer = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.cfin = 1'b1;
                n_state = S_MXL;
            end
            S_MXL: begin
                o_cmd.mul_sel = ddo_pkg::MUL_XLO;
                n_state = S_MXH;
            end
            S_MXH: begin
                o_cmd.mul_sel = ddo_pkg::MUL_XHI;
                o_cmd.ld_lo   = 1'b1;
                n_state = S_MYL;
            end
            S_MYL: begin
                o_cmd.mul_sel = ddo_pkg::MUL_YLO;
                o_cmd.term_x  = 1'b1;
                n_state = S_MYH;
            end
            S_MYH: begin
                o_cmd.mul_sel = ddo_pkg::MUL_YHI;
                o_cmd.ld_lo   = 1'b1;
                o_cmd.add_x   = 1'b1;
                n_state = S_TY;
            end
            S_TY: begin
                o_cmd.term_y = 1'b1;
                n_state = S_AY;
            end
            S_AY: begin
                o_cmd.add_y = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.citer |-> (r_cnt <= LAST))
        else $error("CORDIC iteration beyond the configured count");

    a_fail_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_read_ok) |=> (r_state == S_OUT))
        else $error("failed read did not go straight to the result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

endmodule

// File: hdl/ddo_datapath.sv
module ddo_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ddo_pkg::t_cmd                 i_cmd,
    input  logic                          i_cfg_we,
    input  logic [ddo_pkg::CNT_IDX_W-1:0] i_cfg_idx,
    input  logic [ddo_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [31:0]                   i_left,
    input  logic [31:0]                   i_right,
    input  logic                          i_read_ok,
    output logic [63:0]                   o_pose_x,
    output logic [63:0]                   o_pose_y,
    output logic [31:0]                   o_heading,
    output logic                          o_success
);

    logic [23:0]        r_lpt, r_apt;
    logic [31:0]        r_prev_l, r_prev_r, r_yaw;
    logic [63:0]        r_pos_x, r_pos_y;
    logic [31:0]        r_hs, r_hd;
    logic               r_ok;
    logic [63:0]        r_prod, r_lo, r_term;
    logic [55:0]        r_mag;
    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic [31:0]        r_cx, r_cy;
    logic               r_cx_neg, r_cy_neg;
    logic [63:0]        r_ox, r_oy;
    logic [31:0]        r_oh;
    logic               r_os;

    logic [31:0]        dl, dr, sum, dif, hs_abs;
    logic [31:0]        mul_a, mul_b;
    logic signed [33:0] z0, sx, sy, at, cs, sn;
    logic [63:0]        rnd;

    // Deltas with 32-bit wrap, then halved by arithmetic shift
    assign dl  = i_left - r_prev_l;
    assign dr  = i_right - r_prev_r;
    assign sum = dl + dr;
    assign dif = dl - dr;

    assign hs_abs = r_hs[31] ? (32'd0 - r_hs) : r_hs;

    always_comb begin
        case (i_cmd.mul_sel)
            ddo_pkg::MUL_YAW: begin mul_a = r_hd;                 mul_b = {8'd0, r_apt}; end
            ddo_pkg::MUL_LEN: begin mul_a = hs_abs;               mul_b = {8'd0, r_lpt}; end
            ddo_pkg::MUL_XLO: begin mul_a = r_mag[31:0];          mul_b = r_cx;          end
            ddo_pkg::MUL_XHI: begin mul_a = {8'd0, r_mag[55:32]}; mul_b = r_cx;          end
            ddo_pkg::MUL_YLO: begin mul_a = r_mag[31:0];          mul_b = r_cy;          end
            ddo_pkg::MUL_YHI: begin mul_a = {8'd0, r_mag[55:32]}; mul_b = r_cy;          end
            default:          begin mul_a = '0;                   mul_b = '0;            end
        endcase
    end

    // Heading folded into the right half-plane by a half turn
    always_comb begin
        z0 = 34'(signed'(r_yaw));
        if (z0 > 34'sd1073741824) begin
            z0 = z0 - 34'sd2147483648;
        end else if (z0 < -34'sd1073741824) begin
            z0 = z0 + 34'sd2147483648;
        end
    end

    assign sx = r_x >>> i_cmd.cnt;
    assign sy = r_y >>> i_cmd.cnt;
    assign at = 34'(ddo_pkg::atan_turn(i_cmd.cnt));
    assign cs = r_flip ? -r_x : r_x;
    assign sn = r_flip ? -r_y : r_y;

    // Scaled term: product over 2^30, rounded half away from zero on magnitudes
    assign rnd = {r_prod[61:0], 2'b00} + ((r_lo + 64'd536870912) >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpt    <= 24'd42950;
            r_apt    <= 24'd43000;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_yaw    <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == ddo_pkg::REG_LENGTH_PER_TICK) begin
                r_lpt <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == ddo_pkg::REG_ANGLE_PER_TICK) begin
                r_apt <= i_cfg_data;
            end
            if (i_cmd.ld_in && i_read_ok) begin
                r_prev_l <= i_left;
                r_prev_r <= i_right;
            end
            if (i_cmd.ld_yaw) begin
                r_yaw <= r_yaw + r_prod[31:0];
            end
            if (i_cmd.add_x) begin
                r_pos_x <= r_pos_x + r_term;
            end
            if (i_cmd.add_y) begin
                r_pos_y <= r_pos_y + r_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_hs <= {sum[31], sum[31:1]};
            r_hd <= {dif[31], dif[31:1]};
            r_ok <= i_read_ok;
        end
        r_prod <= 64'(mul_a) * 64'(mul_b);
        if (i_cmd.ld_lo) begin
            r_lo <= r_prod;
        end
        if (i_cmd.cinit) begin
            r_mag  <= r_prod[55:0];
            r_x    <= 34'sd652032874;
            r_y    <= '0;
            r_z    <= z0;
            r_flip <= (z0 != 34'(signed'(r_yaw)));
        end
        if (i_cmd.citer) begin
            if (!r_z[33]) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.cfin) begin
            r_cx_neg <= cs[33];
            r_cy_neg <= sn[33];
            r_cx     <= cs[33] ? 32'(-cs) : cs[31:0];
            r_cy     <= sn[33] ? 32'(-sn) : sn[31:0];
        end
        if (i_cmd.term_x) begin
            r_term <= (r_hs[31] ^ r_cx_neg) ? (64'd0 - rnd) : rnd;
        end
        if (i_cmd.term_y) begin
            r_term <= (r_hs[31] ^ r_cy_neg) ? (64'd0 - rnd) : rnd;
        end
        if (i_cmd.ld_out) begin
            r_ox <= r_ok ? r_pos_x : 64'd0;
            r_oy <= r_ok ? r_pos_y : 64'd0;
            r_oh <= r_ok ? r_yaw : 32'd0;
            r_os <= r_ok;
        end
    end

    assign o_pose_x  = r_ox;
    assign o_pose_y  = r_oy;
    assign o_heading = r_oh;
    assign o_success = r_os;

endmodule

// File: hdl/differential_drive_odometry.sv
// Channel   Direction  Payload                                  Handshake
// i_in      sink       left_count, right_count, read_ok         valid / ready
// o_out     source     pose_x, pose_y, heading, success         valid / ready
// i_cfg_*   write      index 0 length_per_tick, 1 angle_per_tick write enable only
//
// A word with a good read goes from acceptance to its result through the CORDIC
// iterations and through one shared 32x32 multiplier that forms the heading
// step, the step length and the four partial products of the position update.
// A failed read skips the arithmetic and goes straight to the output state.
// Reset is synchronous and clears the pose, previous counts and handshake
// state; the registers return to their defaults. One word is in work at a
// time; a finished result waits in the output register, and a stall there
// holds the next word only at the point where it would overwrite that result.
module differential_drive_odometry #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ddo_in_if.sink                        i_in,
    ddo_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [ddo_pkg::CNT_IDX_W-1:0] i_cfg_idx,
    input  logic [ddo_pkg::CFG_W-1:0]     i_cfg_data
);

    ddo_pkg::t_cmd cmd;
    logic          in_ready;
    logic          out_valid;

    // The controller sequences the shared multiplier and the CORDIC.
    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_read_ok  (i_in.read_ok),
        .i_out_ready(o_out.ready),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .o_cmd      (cmd)
    );

    // The datapath holds the pose, the previous counts and the registers.
    ddo_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_left    (i_in.left_count),
        .i_right   (i_in.right_count),
        .i_read_ok (i_in.read_ok),
        .o_pose_x  (o_out.pose_x),
        .o_pose_y  (o_out.pose_y),
        .o_heading (o_out.heading),
        .o_success (o_out.success)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
